// File: hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants for the URL percent decoder
// Byte codes, status codes, phase encoding, result record and hex lookup.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNul     = 8'h00;

  localparam int unsigned ResDepth = 2;  // output skid queue entries

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ESCAPE = 2'd1,
    ST_ZERO   = 2'd2
  } status_t;

  // one-hot decoder phase
  typedef enum logic [4:0] {
    PH_NORMAL  = 5'b00001,
    PH_PCT     = 5'b00010,
    PH_HIGH    = 5'b00100,
    PH_STOPPED = 5'b01000,
    PH_FAILED  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    status_t    status;
  } res_t;

  // {bad, value}: bad is set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      return {1'b0, d[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      return {1'b0, d[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      return {1'b0, d[3:0]};
    end
    return 5'b1_0000;
  endfunction

endpackage

// File: hw/rtl/url_percent_decoder_unit.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_unit: streaming URL percent decoder
// Each result is registered in the output queue and presented on m_* from there.
// Throughput: one byte per cycle while the output queue is not full, set by
// the single decode step between the phase register and a two-entry output queue.
// Reset (rst, synchronous, active high): phase to normal decoding, sticky
// status to ok, output queue emptied.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // last_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, rest zero
  output logic        m_tuser,   // out_valid
  output logic        m_tlast    // done_res
);

  // --------------------------------------------------------------------------
  // Decoder state: phase, pending high digit, sticky string status.
  // --------------------------------------------------------------------------
  upd_pkg::phase_t  phase, phase_next;
  logic [3:0]       nibble, nibble_next;
  upd_pkg::status_t err, err_next;

  upd_pkg::res_t    res;
  logic [4:0]       hex;
  logic             s_acc;
  logic             m_acc;

  // Output queue: decouples downstream stalls from input acceptance.
  upd_pkg::res_t    queue [upd_pkg::ResDepth];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign s_tready = (count != 2'(upd_pkg::ResDepth));
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  assign hex = upd_pkg::hex_value(s_tdata);

  // --------------------------------------------------------------------------
  // Single-pass decode of one byte.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next    = phase;
    nibble_next   = nibble;
    err_next      = err;
    res.out_byte  = 8'h00;
    res.out_valid = 1'b0;

    case (phase)
      upd_pkg::PH_NORMAL: begin
        if (s_tdata == upd_pkg::ChPercent) begin
          phase_next = upd_pkg::PH_PCT;
        end else if (s_tdata == upd_pkg::ChPlus) begin
          res.out_byte  = upd_pkg::ChSpace;
          res.out_valid = 1'b1;
        end else if (s_tdata == upd_pkg::ChHash) begin
          phase_next = upd_pkg::PH_STOPPED;
        end else if (s_tdata == upd_pkg::ChNul) begin
          err_next   = upd_pkg::ST_ZERO;
          phase_next = upd_pkg::PH_FAILED;
        end else begin
          res.out_byte  = s_tdata;
          res.out_valid = 1'b1;
        end
      end
      upd_pkg::PH_PCT: begin
        if (hex[4]) begin
          err_next   = upd_pkg::ST_ESCAPE;
          phase_next = upd_pkg::PH_FAILED;
        end else begin
          nibble_next = hex[3:0];
          phase_next  = upd_pkg::PH_HIGH;
        end
      end
      upd_pkg::PH_HIGH: begin
        if (hex[4]) begin
          err_next   = upd_pkg::ST_ESCAPE;
          phase_next = upd_pkg::PH_FAILED;
        end else begin
          res.out_byte  = {nibble, hex[3:0]};
          res.out_valid = 1'b1;
          phase_next    = upd_pkg::PH_NORMAL;
        end
      end
      default: begin
        // stopped by '#' or failed: ignore the byte
      end
    endcase

    // escape cut off by the end of the string
    if (s_tlast && (phase_next == upd_pkg::PH_PCT || phase_next == upd_pkg::PH_HIGH)) begin
      err_next   = upd_pkg::ST_ESCAPE;
      phase_next = upd_pkg::PH_FAILED;
    end

    res.done_res = s_tlast;
    res.status   = err_next;

    // end of string: back to a clean start
    if (s_tlast) begin
      phase_next  = upd_pkg::PH_NORMAL;
      nibble_next = 4'h0;
      err_next    = upd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= upd_pkg::PH_NORMAL;
      nibble <= 4'h0;
      err    <= upd_pkg::ST_OK;
    end else if (s_acc) begin
      phase  <= phase_next;
      nibble <= nibble_next;
      err    <= err_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: push on every accepted input, pop on output transaction.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_acc) begin
      queue[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (s_acc) begin
        wr_ptr <= ~wr_ptr;
      end
      if (m_acc) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({s_acc, m_acc})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = {6'h00, queue[rd_ptr].status, queue[rd_ptr].out_byte};
  assign m_tuser  = queue[rd_ptr].out_valid;
  assign m_tlast  = queue[rd_ptr].done_res;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the last byte of a string leaves the decoder clean for the next one
  a_clean_after_last: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> phase == upd_pkg::PH_NORMAL && err == upd_pkg::ST_OK)
    else $error("decoder state not cleared after last byte");

  // a result without a decoded byte carries a zero byte
  a_zero_when_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'h00)
    else $error("out_byte nonzero with out_valid low");

  // '#' is only honored on a string that has not failed
  a_stop_is_ok: assert property (@(posedge clk) disable iff (rst)
    phase == upd_pkg::PH_STOPPED |-> err == upd_pkg::ST_OK)
    else $error("stopped string carries an error status");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !s_tready)
    else $error("input accepted with output queue full");

endmodule
